>>> rtl/core/vhaed_pkg.sv
// Shared types, constants and arithmetic helpers of the appliance event detector.
`default_nettype none

package vhaed_pkg;

    // Number of leading beats used to calibrate the offsets.
    localparam int CAL_SAMPLES = 50;
    localparam int CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);

    localparam int RAW_W   = 10;
    localparam int ACC_W   = 11;
    localparam int JERK_W  = 12;
    localparam int THR_W   = 11;
    localparam int HEAT_W  = 9;
    localparam int RUN_W   = 16;
    localparam int SUM_W   = 16;
    localparam int TSUM_W  = 15;
    localparam int OFF_W   = 10;
    localparam int TOFF_W  = 9;
    localparam int TEMP_W  = 9;
    localparam int TPROD_W = 19;
    localparam int TDIFF_W = 20;
    localparam int TDELTA_W = 10;

    // Division by CAL_SAMPLES as a multiply by a rounded-up reciprocal.
    // The error stays below 2^-DIV_SHIFT * 2^SUM_W, which is under 1/CAL_SAMPLES.
    localparam int DIV_SHIFT = 22;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int DPROD_W   = RECIP_W + SUM_W;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / CAL_SAMPLES + 1;

    localparam int TEMP_SCALE = 500;
    localparam int TEMP_SHIFT = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_DOOR    = 3'd0,
        CFG_Y_DOOR    = 3'd1,
        CFG_Z_DOOR    = 3'd2,
        CFG_QUIET     = 3'd3,
        CFG_HEAT      = 3'd4,
        CFG_RUN_LIMIT = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOOR = 2'd1,
        EV_OFF  = 2'd2,
        EV_ON   = 2'd3
    } event_t;

    typedef struct packed {
        logic [RAW_W-1:0] x_sample;
        logic [RAW_W-1:0] y_sample;
        logic [RAW_W-1:0] z_sample;
        logic [RAW_W-1:0] temp_sample;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       calibrating;
        logic       running;
    } out_beat_t;

    typedef struct packed {
        logic [THR_W-1:0]  x_jerk_limit;
        logic [THR_W-1:0]  y_jerk_limit;
        logic [THR_W-1:0]  z_jerk_limit;
        logic [THR_W-1:0]  quiet_threshold;
        logic [HEAT_W-1:0] heat_threshold;
        logic [RUN_W-1:0]  run_limit_ticks;
    } cfg_t;

    typedef struct packed {
        logic              active;
        logic              busy;
        logic [OFF_W-1:0]  offset_x;
        logic [OFF_W-1:0]  offset_y;
        logic [OFF_W-1:0]  offset_z;
        logic [TOFF_W-1:0] offset_temp;
    } cal_info_t;

    // Raw temperature times 500, full precision.
    function automatic logic [TPROD_W-1:0] temp_product(input logic [RAW_W-1:0] raw);
        logic [TPROD_W-1:0] p;
        p = TPROD_W'(raw) * TPROD_W'(TEMP_SCALE);
        return p;
    endfunction

    // floor(raw * 500 / 1024)
    function automatic logic [TEMP_W-1:0] temp_scale(input logic [RAW_W-1:0] raw);
        logic [TPROD_W-1:0] p;
        p = temp_product(raw);
        return p[TEMP_SHIFT +: TEMP_W];
    endfunction

    // floor(s / CAL_SAMPLES)
    function automatic logic [SUM_W-1:0] div_cal(input logic [SUM_W-1:0] s);
        logic [DPROD_W-1:0] p;
        p = DPROD_W'(s) * DPROD_W'(DIV_RECIP);
        return p[DIV_SHIFT +: SUM_W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/vhaed_cfg_regs.sv
// Configuration register file with reset defaults.
`default_nettype none

module vhaed_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [vhaed_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [vhaed_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output vhaed_pkg::cfg_t                     cfg
);
    import vhaed_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_jerk_limit    <= THR_W'(30);
            cfg_reg.y_jerk_limit    <= THR_W'(30);
            cfg_reg.z_jerk_limit    <= THR_W'(70);
            cfg_reg.quiet_threshold <= THR_W'(5);
            cfg_reg.heat_threshold  <= HEAT_W'(3);
            cfg_reg.run_limit_ticks <= RUN_W'(5400);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_X_DOOR:    cfg_reg.x_jerk_limit    <= cfg_wr_data[THR_W-1:0];
                CFG_Y_DOOR:    cfg_reg.y_jerk_limit    <= cfg_wr_data[THR_W-1:0];
                CFG_Z_DOOR:    cfg_reg.z_jerk_limit    <= cfg_wr_data[THR_W-1:0];
                CFG_QUIET:     cfg_reg.quiet_threshold <= cfg_wr_data[THR_W-1:0];
                CFG_HEAT:      cfg_reg.heat_threshold  <= cfg_wr_data[HEAT_W-1:0];
                CFG_RUN_LIMIT: cfg_reg.run_limit_ticks <= cfg_wr_data[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/vhaed_calib.sv
// Calibration accumulator and offset computation.
`default_nettype none

module vhaed_calib (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire vhaed_pkg::in_beat_t sample,
    output vhaed_pkg::cal_info_t     cal
);
    import vhaed_pkg::*;

    logic [CAL_CNT_W-1:0] cal_count_reg;
    logic [CAL_CNT_W-1:0] cal_count_next;
    logic [SUM_W-1:0]     sum_x_reg, sum_y_reg, sum_z_reg;
    logic [TSUM_W-1:0]    sum_temp_reg;
    logic [OFF_W-1:0]     offset_x_reg, offset_y_reg, offset_z_reg;
    logic [TOFF_W-1:0]    offset_temp_reg;
    logic                 settle_reg;
    logic                 active;
    logic [SUM_W-1:0]     q_x, q_y, q_z, q_temp;

    assign active         = (cal_count_reg < CAL_CNT_W'(CAL_SAMPLES));
    assign cal_count_next = cal_count_reg + CAL_CNT_W'(1);

    // Quotients are taken from the registered sums in the cycle after the last
    // calibration beat, while cal.busy holds the pipeline off.
    assign q_x    = div_cal(sum_x_reg);
    assign q_y    = div_cal(sum_y_reg);
    assign q_z    = div_cal(sum_z_reg);
    assign q_temp = div_cal(SUM_W'(sum_temp_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_count_reg <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            sum_temp_reg  <= '0;
            settle_reg    <= 1'b0;
        end else begin
            settle_reg <= 1'b0;
            if (step && active) begin
                cal_count_reg <= cal_count_next;
                sum_x_reg     <= sum_x_reg + SUM_W'(sample.x_sample);
                sum_y_reg     <= sum_y_reg + SUM_W'(sample.y_sample);
                sum_z_reg     <= sum_z_reg + SUM_W'(sample.z_sample);
                sum_temp_reg  <= sum_temp_reg + TSUM_W'(temp_scale(sample.temp_sample));
                if (cal_count_next == CAL_CNT_W'(CAL_SAMPLES)) begin
                    settle_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (settle_reg) begin
            offset_x_reg    <= q_x[OFF_W-1:0];
            offset_y_reg    <= q_y[OFF_W-1:0];
            offset_z_reg    <= q_z[OFF_W-1:0];
            offset_temp_reg <= q_temp[TOFF_W-1:0];
        end
    end

    assign cal.active      = active;
    assign cal.busy        = settle_reg;
    assign cal.offset_x    = offset_x_reg;
    assign cal.offset_y    = offset_y_reg;
    assign cal.offset_z    = offset_z_reg;
    assign cal.offset_temp = offset_temp_reg;

    // The offset load happens exactly once, right when calibration ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        settle_reg |-> !active && $past(active))
        else $error("offset load outside the end of calibration");

endmodule

`default_nettype wire

>>> rtl/core/vhaed_detect.sv
// Event decision logic and the detector state after calibration.
`default_nettype none

module vhaed_detect (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire vhaed_pkg::in_beat_t  sample,
    input  wire vhaed_pkg::cal_info_t cal,
    input  wire vhaed_pkg::cfg_t      cfg,
    output vhaed_pkg::event_t         event_res,
    output logic                      running_next
);
    import vhaed_pkg::*;

    logic signed [ACC_W-1:0]   prev_x_reg, prev_y_reg, prev_z_reg;
    logic                      door_seen_reg;
    logic                      running_reg;
    logic [RUN_W-1:0]          run_ticks_reg;
    logic [RUN_W-1:0]          run_ticks_next;

    logic signed [ACC_W-1:0]   ax, ay, az;
    logic signed [JERK_W-1:0]  jx, jy, jz;
    logic [JERK_W-1:0]         jx_mag, jy_mag, jz_mag;
    logic [ACC_W-1:0]          ax_mag, ay_mag, az_mag;
    logic signed [TDIFF_W-1:0] tdiff;
    logic [TDIFF_W-1:0]        tdiff_mag;
    logic [TDELTA_W-1:0]       tdelta;
    logic                      door_hit, off_hit, on_hit;

    assign ax = $signed({1'b0, sample.x_sample}) - $signed({1'b0, cal.offset_x});
    assign ay = $signed({1'b0, sample.y_sample}) - $signed({1'b0, cal.offset_y});
    assign az = $signed({1'b0, sample.z_sample}) - $signed({1'b0, cal.offset_z});

    assign jx = JERK_W'(ax) - JERK_W'(prev_x_reg);
    assign jy = JERK_W'(ay) - JERK_W'(prev_y_reg);
    assign jz = JERK_W'(az) - JERK_W'(prev_z_reg);

    assign jx_mag = jx[JERK_W-1] ? JERK_W'(-jx) : JERK_W'(jx);
    assign jy_mag = jy[JERK_W-1] ? JERK_W'(-jy) : JERK_W'(jy);
    assign jz_mag = jz[JERK_W-1] ? JERK_W'(-jz) : JERK_W'(jz);
    assign ax_mag = ax[ACC_W-1] ? ACC_W'(-ax) : ACC_W'(ax);
    assign ay_mag = ay[ACC_W-1] ? ACC_W'(-ay) : ACC_W'(ay);
    assign az_mag = az[ACC_W-1] ? ACC_W'(-az) : ACC_W'(az);

    // Exact temperature delta: |raw*500 - offset*1024| / 1024, toward zero.
    assign tdiff = $signed({1'b0, temp_product(sample.temp_sample)})
                 - $signed({1'b0, cal.offset_temp, {TEMP_SHIFT{1'b0}}});
    assign tdiff_mag = tdiff[TDIFF_W-1] ? TDIFF_W'(-tdiff) : TDIFF_W'(tdiff);
    assign tdelta    = tdiff_mag[TEMP_SHIFT +: TDELTA_W];

    assign door_hit = ((jx_mag > JERK_W'(cfg.x_jerk_limit))
                    || (jy_mag > JERK_W'(cfg.y_jerk_limit)))
                    && (jz_mag > JERK_W'(cfg.z_jerk_limit))
                    && !door_seen_reg;
    assign off_hit  = ((ax_mag < cfg.quiet_threshold) && (ay_mag < cfg.quiet_threshold)
                    && (az_mag < cfg.quiet_threshold) && running_reg)
                    || (run_ticks_reg > cfg.run_limit_ticks);
    assign on_hit   = (tdelta > TDELTA_W'(cfg.heat_threshold)) && !running_reg;

    always_comb begin
        event_res    = EV_NONE;
        running_next = running_reg;
        if (door_hit) begin
            event_res = EV_DOOR;
        end else if (off_hit) begin
            event_res    = EV_OFF;
            running_next = 1'b0;
        end else if (on_hit) begin
            event_res    = EV_ON;
            running_next = 1'b1;
        end
    end

    always_comb begin
        run_ticks_next = '0;
        if (running_next) begin
            run_ticks_next = (run_ticks_reg == RUN_MAX) ? RUN_MAX
                                                        : run_ticks_reg + RUN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            door_seen_reg <= 1'b0;
            running_reg   <= 1'b0;
            run_ticks_reg <= '0;
        end else if (step) begin
            prev_x_reg    <= ax;
            prev_y_reg    <= ay;
            prev_z_reg    <= az;
            running_reg   <= running_next;
            run_ticks_reg <= run_ticks_next;
            if (door_hit) begin
                door_seen_reg <= 1'b1;
            end
        end
    end

    // The door event is one-shot: once seen, the flag never drops.
    assert property (@(posedge aclk) disable iff (!aresetn)
        door_seen_reg |=> door_seen_reg)
        else $error("door flag cleared after it was set");

    // The run counter only counts while the machine runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> run_ticks_reg == '0)
        else $error("run counter nonzero while stopped");

endmodule

`default_nettype wire

>>> rtl/core/vibration_heat_appliance_event_detector_core.sv
// Top level of the appliance event detector: input register, decision, result register.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_data  (x, y, z, temperature samples)
//   m_       out        m_valid / m_ready    m_data  (event, calibrating, running)
//   cfg_     in         cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// Each beat passes the input register and the decision logic into the result
// register, and one beat is taken every cycle while the pipeline does not stall.
// The exception is the end of calibration: the offsets are divided out of the
// registered sums while cal.busy is high, and the decision stage holds meanwhile.
// A stalled result register holds the pipeline; the input register still
// takes a beat as long as it is empty. Reset is synchronous and active low.
`default_nettype none

module vibration_heat_appliance_event_detector_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire vhaed_pkg::in_beat_t              s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output vhaed_pkg::out_beat_t                  m_data,
    input  wire logic                             cfg_wr_en,
    input  wire logic [vhaed_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [vhaed_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import vhaed_pkg::*;

    cfg_t      cfg;
    cal_info_t cal;
    event_t    det_event;
    logic      det_running;

    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    out_beat_t result;
    logic      advance;

    assign advance = in_valid_reg && !cal.busy && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    vhaed_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    vhaed_calib u_calib (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .sample  (in_data_reg),
        .cal     (cal)
    );

    vhaed_detect u_detect (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance && !cal.active),
        .sample       (in_data_reg),
        .cal          (cal),
        .cfg          (cfg),
        .event_res    (det_event),
        .running_next (det_running)
    );

    always_comb begin
        if (cal.active) begin
            result.event_res   = EV_NONE;
            result.calibrating = 1'b1;
            result.running     = 1'b0;
        end else begin
            result.event_res   = det_event;
            result.calibrating = 1'b0;
            result.running     = det_running;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A calibration beat never carries an event or a running machine.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.calibrating |-> m_data.event_res == EV_NONE && !m_data.running)
        else $error("calibration beat with an event or running flag");

    // A beat held in the input register must not be lost when a new one enters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |-> !s_ready)
        else $error("input register overwritten before it was consumed");

endmodule

`default_nettype wire
